[rtl/sot_pkg.sv]
// sot_pkg: shared types and constants for the sorted offset table
// field widths, operation and status codes, and the beat that travels the cell chain
// no dependencies
package sot_pkg;

	// default table depth
	localparam int SOT_DEPTH = 256;

	// field widths
	localparam int KEY_W  = 16;
	localparam int OFF_W  = 32;
	localparam int CRD_W  = 40;
	localparam int STAT_W = 3;
	localparam int CNT_W  = 9;

	// operation codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	// result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_INSERTED = 3'd0,
		ST_DUP      = 3'd1,
		ST_FULL     = 3'd2,
		ST_HIT      = 3'd3,
		ST_MISS     = 3'd4
	} status_t;

	// what a beat is doing as it walks the chain
	typedef enum logic [1:0] {
		MD_IDLE,
		MD_SEARCH,
		MD_CARRY,
		MD_DONE
	} mode_t;

	// beat handed from cell to cell
	typedef struct packed {
		mode_t             mode;
		logic              op;
		status_t           status;
		logic [KEY_W-1:0]  key;
		logic [OFF_W-1:0]  ox;
		logic [OFF_W-1:0]  oy;
	} beat_t;

endpackage

[rtl/sot_cell.sv]
// sot_cell: one slot of the sorted table plus the beat register to its neighbor
// compares, stores, and swaps entries as a beat walks past
// depends on sot_pkg
module sot_cell #(
	parameter int DEPTH = sot_pkg::SOT_DEPTH,
	parameter int INDEX = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [$clog2(DEPTH+1)-1:0]    count,
	input  logic                          full,
	input  sot_pkg::beat_t                beat_in,
	output sot_pkg::beat_t                beat_out
);
	import sot_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic [KEY_W-1:0] key_q;
	logic [OFF_W-1:0] ox_q;
	logic [OFF_W-1:0] oy_q;
	beat_t            beat_q;
	beat_t            beat_d;
	logic             slot_valid;
	logic             wr;
	logic             key_eq;
	logic             key_lt;

	// slot holds data only below the fill count
	assign slot_valid = (count > CW'(INDEX));
	assign key_eq     = slot_valid && (key_q == beat_in.key);
	assign key_lt     = slot_valid && (key_q < beat_in.key);

	always_comb begin
		beat_d = beat_in;
		wr     = 1'b0;
		case (beat_in.mode)
			MD_SEARCH: begin
				if (key_eq) begin
					if (beat_in.op == OP_INSERT) begin
						beat_d.mode   = MD_DONE;
						beat_d.status = ST_DUP;
					end else begin
						// hit: pick up stored offsets
						beat_d.mode   = MD_DONE;
						beat_d.status = ST_HIT;
						beat_d.ox     = ox_q;
						beat_d.oy     = oy_q;
					end
				end else if (key_lt) begin
					// keep walking
					beat_d = beat_in;
				end else if (beat_in.op == OP_LOOKUP) begin
					beat_d.mode   = MD_DONE;
					beat_d.status = ST_MISS;
				end else if (full) begin
					beat_d.mode   = MD_DONE;
					beat_d.status = ST_FULL;
				end else begin
					// insert point: take new entry, carry the old one onward
					wr = 1'b1;
					if (slot_valid) begin
						beat_d.mode = MD_CARRY;
						beat_d.key  = key_q;
						beat_d.ox   = ox_q;
						beat_d.oy   = oy_q;
					end else begin
						beat_d.mode   = MD_DONE;
						beat_d.status = ST_INSERTED;
					end
				end
			end
			MD_CARRY: begin
				wr = 1'b1;
				if (slot_valid) begin
					beat_d.key = key_q;
					beat_d.ox  = ox_q;
					beat_d.oy  = oy_q;
				end else begin
					beat_d.mode   = MD_DONE;
					beat_d.status = ST_INSERTED;
				end
			end
			default: begin
				beat_d = beat_in;
			end
		endcase
	end

	// slot payload, no reset
	always_ff @(posedge clk) begin
		if (wr) begin
			key_q <= beat_in.key;
			ox_q  <= beat_in.ox;
			oy_q  <= beat_in.oy;
		end
	end

	// beat register toward the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q.mode <= MD_IDLE;
		end else begin
			beat_q <= beat_d;
		end
	end

	assign beat_out = beat_q;

endmodule

[rtl/sorted_offset_table_correct_top.sv]
// sorted_offset_table_correct_top: sorted key/offset table with lookup and correction
// a row of sot_cell slots; an input beat walks the row one cell per cycle
// depends on sot_pkg and sot_cell
//
//  channel   ports                                              handshake
//  --------  -------------------------------------------------  -------------------------
//  input     operation key offset_x offset_y coord_x coord_y    taken when start & !busy
//  result    status corrected_x corrected_y entry_count         one cycle, marked by done
//
// every item goes through these steps between the accepting edge and the next possible
// accept: the launch register is loaded at the accepting edge, the beat walks the cell
// row one cell per cycle, the result registers take the 40-bit subtract, and then busy
// is low while done shows the result
// busy is high from accept until the edge that loads the result; done is high
// the cycle after, and start may already be taken in that same cycle
// reset clears the fill count, busy, done and the beat modes; slot contents are left
// alone since only slots below the fill count are ever looked at
// the result cannot be held off by the receiver; it is shown for one cycle only
module sorted_offset_table_correct_top #(
	parameter int DEPTH = sot_pkg::SOT_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                operation,
	input  logic [sot_pkg::KEY_W-1:0]           key,
	input  logic signed [sot_pkg::OFF_W-1:0]    offset_x,
	input  logic signed [sot_pkg::OFF_W-1:0]    offset_y,
	input  logic signed [sot_pkg::CRD_W-1:0]    coord_x,
	input  logic signed [sot_pkg::CRD_W-1:0]    coord_y,
	output logic                                done,
	output logic [sot_pkg::STAT_W-1:0]          status,
	output logic signed [sot_pkg::CRD_W-1:0]    corrected_x,
	output logic signed [sot_pkg::CRD_W-1:0]    corrected_y,
	output logic [sot_pkg::CNT_W-1:0]           entry_count
);
	import sot_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	// fill count and control
	logic [CW-1:0]     count_q;
	logic              busy_q;
	logic              full;
	logic              accept;

	// coordinates held for the whole walk
	logic [CRD_W-1:0]  cx_q;
	logic [CRD_W-1:0]  cy_q;

	// beat chain: entry 0 is the launch register, entry i+1 leaves cell i
	beat_t             launch_q;
	beat_t             chain [DEPTH+1];
	beat_t             fin;

	// final decode of the beat leaving the last cell
	status_t           fin_status;
	logic              fin_live;
	logic              fin_ins;
	logic [CW-1:0]     count_d;

	// result registers
	logic              done_q;
	status_t           status_q;
	logic [CRD_W-1:0]  rx_q;
	logic [CRD_W-1:0]  ry_q;
	logic [CNT_W-1:0]  cnt_q;

	assign accept = start && !busy_q;
	assign full   = (count_q == CW'(DEPTH));

	// launch a beat into cell 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launch_q.mode <= MD_IDLE;
		end else begin
			launch_q.mode   <= accept ? MD_SEARCH : MD_IDLE;
			launch_q.op     <= operation;
			launch_q.status <= ST_MISS;
			launch_q.key    <= key;
			launch_q.ox     <= offset_x;
			launch_q.oy     <= offset_y;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cx_q <= coord_x;
			cy_q <= coord_y;
		end
	end

	assign chain[0] = launch_q;

	// the cell row
	for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
		sot_cell #(
			.DEPTH (DEPTH),
			.INDEX (gi)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.count    (count_q),
			.full     (full),
			.beat_in  (chain[gi]),
			.beat_out (chain[gi+1])
		);
	end

	assign fin = chain[DEPTH];

	// a beat still searching at the end ran past every slot: full table or miss
	always_comb begin
		fin_live = 1'b1;
		case (fin.mode)
			MD_DONE:   fin_status = fin.status;
			MD_SEARCH: fin_status = (fin.op == OP_INSERT) ? ST_FULL : ST_MISS;
			MD_CARRY:  fin_status = ST_INSERTED;
			default: begin
				fin_status = ST_MISS;
				fin_live   = 1'b0;
			end
		endcase
	end

	assign fin_ins = fin_live && (fin_status == ST_INSERTED);
	assign count_d = fin_ins ? (count_q + CW'(1)) : count_q;

	// control: fill count, busy, strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			done_q  <= fin_live;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (fin_live) begin
				busy_q <= 1'b0;
			end
		end
	end

	// result beat: subtract the sign-extended offsets on a hit
	always_ff @(posedge clk) begin
		if (fin_live) begin
			status_q <= fin_status;
			cnt_q    <= CNT_W'(count_d);
			if (fin_status == ST_HIT) begin
				rx_q <= cx_q - {{(CRD_W-OFF_W){fin.ox[OFF_W-1]}}, fin.ox};
				ry_q <= cy_q - {{(CRD_W-OFF_W){fin.oy[OFF_W-1]}}, fin.oy};
			end else begin
				rx_q <= '0;
				ry_q <= '0;
			end
		end
	end

	assign busy        = busy_q;
	assign done        = done_q;
	assign status      = status_q;
	assign corrected_x = rx_q;
	assign corrected_y = ry_q;
	assign entry_count = cnt_q;

endmodule

[tb/tb_sorted_offset_table_correct_top.sv]
`timescale 1ns / 1ps
// self-checking testbench for sorted_offset_table_correct_top (sorted key table with lookup)
// depends on sot_pkg and the block; holds its own table predictor and checks every result
module tb_sorted_offset_table_correct_top;
	import sot_pkg::*;

	localparam int DEPTH       = SOT_DEPTH;
	// rough number of random beats
	localparam int N_RANDOM    = 680;
	// window of random beats sent back to back with no idling
	localparam int CALM_FROM   = 250;
	localparam int CALM_TO     = 400;
	// distinct keys handed out for fresh inserts, a little more than the table holds
	localparam int POOL_SIZE   = 320;
	// one item holds the block while busy; allow the longest sender gap on top, several times
	localparam int WATCH_LIMIT = 4 * (2 * DEPTH + 16);

	// one command beat as driven on the input ports
	typedef struct packed {
		logic             op;
		logic [KEY_W-1:0] key;
		logic [OFF_W-1:0] ox;
		logic [OFF_W-1:0] oy;
		logic [CRD_W-1:0] cx;
		logic [CRD_W-1:0] cy;
	} table_cmd_t;

	// one result beat as seen on the result ports
	typedef struct packed {
		status_t          st;
		logic [CRD_W-1:0] rx;
		logic [CRD_W-1:0] ry;
		logic [CNT_W-1:0] cnt;
	} table_reply_t;

	// directed row: command plus, where obvious, the reply typed in by hand
	typedef struct packed {
		table_cmd_t   cmd;
		logic         typed;
		table_reply_t reply;
	} script_row_t;

	localparam logic [OFF_W-1:0] ONE_DEG  = 32'h0100_0000;
	localparam logic [OFF_W-1:0] MONE_DEG = 32'hFF00_0000;
	localparam logic [OFF_W-1:0] OFF_MAX  = 32'h7FFF_FFFF;
	localparam logic [OFF_W-1:0] OFF_MIN  = 32'h8000_0000;
	localparam logic [CRD_W-1:0] CRD_MAX  = 40'h7F_FFFF_FFFF;
	localparam logic [CRD_W-1:0] CRD_MIN  = 40'h80_0000_0000;
	localparam logic [CRD_W-1:0] CRD_ONES = 40'hFF_FFFF_FFFF;
	localparam logic [CRD_W-1:0] CRD_ONE  = 40'h00_0100_0000;

	localparam int N_SCRIPT = 21;
	// fields: op key ox oy cx cy | typed | status rx ry count
	localparam script_row_t SCRIPT [N_SCRIPT] = '{
		// lookup straight after reset: empty table, nothing compared
		'{'{OP_LOOKUP, 16'd0, 32'd0, 32'd0, 40'd0, 40'd0}, 1'b1,
			'{ST_MISS, 40'd0, 40'd0, 9'd0}},
		// first insert; coordinates are ignored by an insert
		'{'{OP_INSERT, 16'd1000, ONE_DEG, MONE_DEG, CRD_ONES, CRD_ONES}, 1'b1,
			'{ST_INSERTED, 40'd0, 40'd0, 9'd1}},
		// head insertion with extreme offsets, must keep the existing entry
		'{'{OP_INSERT, 16'd0, OFF_MAX, OFF_MIN, 40'd0, 40'd0}, 1'b1,
			'{ST_INSERTED, 40'd0, 40'd0, 9'd2}},
		// tail insertion at the top key
		'{'{OP_INSERT, 16'hFFFF, OFF_MIN, OFF_MAX, CRD_MIN, CRD_MAX}, 1'b1,
			'{ST_INSERTED, 40'd0, 40'd0, 9'd3}},
		// duplicate key, offsets must not be overwritten
		'{'{OP_INSERT, 16'd1000, 32'h1234_5678, 32'h9ABC_DEF0, 40'd0, 40'd0}, 1'b1,
			'{ST_DUP, 40'd0, 40'd0, 9'd3}},
		// middle insertion
		'{'{OP_INSERT, 16'd500, 32'd0, 32'hFFFF_FFFF, 40'd0, 40'd0}, 1'b1,
			'{ST_INSERTED, 40'd0, 40'd0, 9'd4}},
		// 1.0 - 1.0 and 0 - (-1.0): still the first offsets
		'{'{OP_LOOKUP, 16'd1000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, CRD_ONE, 40'd0}, 1'b1,
			'{ST_HIT, 40'd0, CRD_ONE, 9'd4}},
		'{'{OP_LOOKUP, 16'd0, 32'd0, 32'd0, 40'd0, 40'd0}, 1'b0, '0},
		// coordinate extremes, differences wrap
		'{'{OP_LOOKUP, 16'hFFFF, 32'd0, 32'd0, CRD_MAX, CRD_MIN}, 1'b0, '0},
		'{'{OP_LOOKUP, 16'd0, 32'd0, 32'd0, CRD_MIN, CRD_MAX}, 1'b0, '0},
		'{'{OP_LOOKUP, 16'd500, 32'd0, 32'd0, CRD_ONES, CRD_ONES}, 1'b0, '0},
		// misses right beside stored keys; offsets on a lookup are ignored
		'{'{OP_LOOKUP, 16'd999, OFF_MAX, OFF_MIN, CRD_MAX, CRD_MAX}, 1'b1,
			'{ST_MISS, 40'd0, 40'd0, 9'd4}},
		'{'{OP_LOOKUP, 16'hFFFE, 32'd0, 32'd0, CRD_ONES, CRD_ONES}, 1'b1,
			'{ST_MISS, 40'd0, 40'd0, 9'd4}},
		// neighbours of an existing key on both sides
		'{'{OP_INSERT, 16'd999, 32'h0000_0001, 32'h8000_0001, 40'd0, 40'd0}, 1'b1,
			'{ST_INSERTED, 40'd0, 40'd0, 9'd5}},
		'{'{OP_INSERT, 16'd1001, 32'h7FFF_FFFE, 32'h00FF_FFFF, 40'd0, 40'd0}, 1'b1,
			'{ST_INSERTED, 40'd0, 40'd0, 9'd6}},
		// duplicates at both ends
		'{'{OP_INSERT, 16'd0, 32'd5, 32'd5, 40'd0, 40'd0}, 1'b1,
			'{ST_DUP, 40'd0, 40'd0, 9'd6}},
		'{'{OP_INSERT, 16'hFFFF, 32'd5, 32'd5, 40'd0, 40'd0}, 1'b1,
			'{ST_DUP, 40'd0, 40'd0, 9'd6}},
		// read back after the shifts
		'{'{OP_LOOKUP, 16'd1001, 32'd0, 32'd0, 40'h12_3456_789A, CRD_MIN}, 1'b0, '0},
		'{'{OP_LOOKUP, 16'd999, 32'd0, 32'd0, CRD_MIN, 40'h00_0000_0001}, 1'b0, '0},
		'{'{OP_LOOKUP, 16'd1000, 32'd0, 32'd0, CRD_MAX, CRD_ONES}, 1'b0, '0},
		'{'{OP_LOOKUP, 16'hFFFF, 32'd0, 32'd0, 40'd0, 40'd0}, 1'b0, '0}
	};

	logic                    clk;
	logic                    arst_n    = 1'b0;
	logic                    start     = 1'b0;
	logic                    operation = OP_INSERT;
	logic [KEY_W-1:0]        key       = '0;
	logic signed [OFF_W-1:0] offset_x  = '0;
	logic signed [OFF_W-1:0] offset_y  = '0;
	logic signed [CRD_W-1:0] coord_x   = '0;
	logic signed [CRD_W-1:0] coord_y   = '0;
	logic                    busy;
	logic                    done;
	logic [STAT_W-1:0]       status;
	logic signed [CRD_W-1:0] corrected_x;
	logic signed [CRD_W-1:0] corrected_y;
	logic [CNT_W-1:0]        entry_count;

	// predictor copy of the table, kept in ascending key order
	logic [KEY_W-1:0] tbl_key [DEPTH];
	logic [OFF_W-1:0] tbl_ox  [DEPTH];
	logic [OFF_W-1:0] tbl_oy  [DEPTH];
	int               tbl_fill = 0;

	table_reply_t     replies_due [$];
	logic [KEY_W-1:0] key_pool [$];
	bit               pool_seen [logic [KEY_W-1:0]];
	int               pool_next   = 0;
	int               mismatches  = 0;
	int               quiet_cycles = 0;

	sorted_offset_table_correct_top #(
		.DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.key(key),
		.offset_x(offset_x),
		.offset_y(offset_y),
		.coord_x(coord_x),
		.coord_y(coord_y),
		.done(done),
		.status(status),
		.corrected_x(corrected_x),
		.corrected_y(corrected_y),
		.entry_count(entry_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// apply one command to the predictor table and return the reply it owes
	function automatic table_reply_t apply_table_cmd(input table_cmd_t c);
		table_reply_t r;
		int           hit;
		int           pos;
		r   = '0;
		hit = -1;
		// only slots below the fill count take part in the search
		for (int i = 0; i < tbl_fill; i++) begin
			if (hit < 0 && tbl_key[i] == c.key)
				hit = i;
		end
		if (c.op == OP_INSERT) begin
			if (hit >= 0) begin
				r.st = ST_DUP;
			end else if (tbl_fill >= DEPTH) begin
				r.st = ST_FULL;
			end else begin
				// move larger keys up one slot, then drop the new one in the hole
				pos = tbl_fill;
				while (pos > 0 && tbl_key[pos-1] > c.key) begin
					tbl_key[pos] = tbl_key[pos-1];
					tbl_ox[pos]  = tbl_ox[pos-1];
					tbl_oy[pos]  = tbl_oy[pos-1];
					pos--;
				end
				tbl_key[pos] = c.key;
				tbl_ox[pos]  = c.ox;
				tbl_oy[pos]  = c.oy;
				tbl_fill++;
				r.st = ST_INSERTED;
			end
		end else if (hit >= 0) begin
			// sign-extend the q8.24 offset to 40 bits, subtract modulo 2^40
			r.st = ST_HIT;
			r.rx = c.cx - {{(CRD_W-OFF_W){tbl_ox[hit][OFF_W-1]}}, tbl_ox[hit]};
			r.ry = c.cy - {{(CRD_W-OFF_W){tbl_oy[hit][OFF_W-1]}}, tbl_oy[hit]};
		end else begin
			r.st = ST_MISS;
		end
		r.cnt = CNT_W'(tbl_fill);
		return r;
	endfunction

	function automatic logic [CRD_W-1:0] rand_crd();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[CRD_W-1:0];
	endfunction

	// command with the given op and key, random offsets and coordinates
	function automatic table_cmd_t make_cmd(input logic op, input logic [KEY_W-1:0] k);
		table_cmd_t c;
		c.op  = op;
		c.key = k;
		c.ox  = $urandom;
		c.oy  = $urandom;
		c.cx  = rand_crd();
		c.cy  = rand_crd();
		return c;
	endfunction

	// random mix: mostly fresh inserts from the pool and hits on stored keys,
	// with duplicates, misses and fully random keys as noise
	function automatic table_cmd_t random_cmd();
		int               r;
		int               s;
		logic [KEY_W-1:0] k;
		r = $urandom_range(0, 99);
		s = $urandom_range(0, 99);
		k = KEY_W'($urandom_range(0, 65535));
		if (r < 55) begin
			if (s < 80 && pool_next < key_pool.size()) begin
				k = key_pool[pool_next];
				pool_next++;
			end else if (s < 95 && tbl_fill > 0) begin
				k = tbl_key[$urandom_range(0, tbl_fill - 1)];
			end
			return make_cmd(OP_INSERT, k);
		end
		if (s < 65 && tbl_fill > 0)
			k = tbl_key[$urandom_range(0, tbl_fill - 1)];
		else if (s < 80 && pool_next < key_pool.size())
			k = key_pool[$urandom_range(pool_next, key_pool.size() - 1)];
		return make_cmd(OP_LOOKUP, k);
	endfunction

	// idle before the next beat: mostly short, sometimes long enough to end
	// near the point where the block frees up
	function automatic int pick_idle(input bit calm);
		if (calm || $urandom_range(0, 99) >= 31)
			return 0;
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(1, DEPTH + 2);
		return $urandom_range(1, 3);
	endfunction

	// drive one beat from a rising edge and return at the edge that takes it;
	// start stays high into the next beat when there is no idle
	task automatic issue(input table_cmd_t c, input logic typed, input table_reply_t hand,
			input int idle, input bit drain);
		table_reply_t r;
		if (idle > 0 || (drain && replies_due.size() != 0)) begin
			start <= 1'b0;
			repeat (idle) @(posedge clk);
			while (drain && replies_due.size() != 0)
				@(posedge clk);
		end
		start     <= 1'b1;
		operation <= c.op;
		key       <= c.key;
		offset_x  <= c.ox;
		offset_y  <= c.oy;
		coord_x   <= c.cx;
		coord_y   <= c.cy;
		// decide at the falling edge whether the coming edge takes the beat
		do
			@(negedge clk);
		while (busy !== 1'b0);
		@(posedge clk);
		r = apply_table_cmd(c);
		replies_due.push_back(typed ? hand : r);
	endtask

	// result check and watchdog, both at the falling edge where every port is settled
	always @(negedge clk) begin
		table_reply_t want;
		if (arst_n) begin
			if (done === 1'b1) begin
				if (replies_due.size() == 0) begin
					$error("result beat with nothing outstanding: status %0d", status);
					mismatches++;
				end else begin
					want = replies_due.pop_front();
					if (status !== want.st) begin
						$error("status: expected %0d, actual %0d", want.st, status);
						mismatches++;
					end
					if (corrected_x !== want.rx) begin
						$error("corrected_x: expected %h, actual %h", want.rx, corrected_x);
						mismatches++;
					end
					if (corrected_y !== want.ry) begin
						$error("corrected_y: expected %h, actual %h", want.ry, corrected_y);
						mismatches++;
					end
					if (entry_count !== want.cnt) begin
						$error("entry_count: expected %0d, actual %0d", want.cnt, entry_count);
						mismatches++;
					end
				end
			end
			// any beat moving on either side counts as progress
			if (done === 1'b1 || (start && busy === 1'b0))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCH_LIMIT) begin
				$display("[sorted_offset_table_correct_top] ERROR");
				$finish;
			end
		end
	end

	initial begin
		logic [KEY_W-1:0] k;
		table_cmd_t       c;
		// distinct keys for fresh inserts, in random order
		while (key_pool.size() < POOL_SIZE) begin
			k = KEY_W'($urandom_range(0, 65535));
			if (!pool_seen.exists(k)) begin
				pool_seen[k] = 1'b1;
				key_pool.push_back(k);
			end
		end

		// reset once, then release
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part: empty table, ordering at head/middle/tail, duplicates,
		// misses, offset and coordinate extremes with wrap
		for (int i = 0; i < N_SCRIPT; i++)
			issue(SCRIPT[i].cmd, SCRIPT[i].typed, SCRIPT[i].reply, pick_idle(1'b0), 1'b0);

		// hold off until the table has answered everything so far
		issue(random_cmd(), 1'b0, '0, 0, 1'b1);

		// random part; the table fills up along the way and later inserts of new
		// keys meet a full table
		for (int i = 0; i < N_RANDOM; i++)
			issue(random_cmd(), 1'b0, '0, pick_idle(i >= CALM_FROM && i < CALM_TO),
				$urandom_range(0, 49) == 0);

		// top the table up if the random mix fell short of capacity
		while (tbl_fill < DEPTH) begin
			if (pool_next < key_pool.size()) begin
				k = key_pool[pool_next];
				pool_next++;
			end else begin
				k = KEY_W'($urandom_range(0, 65535));
			end
			issue(make_cmd(OP_INSERT, k), 1'b0, '0, pick_idle(1'b0), 1'b0);
		end

		// full table: new key is dropped, a duplicate still reports as duplicate,
		// both ends of the table are reachable
		issue(make_cmd(OP_INSERT, KEY_W'($urandom_range(0, 65535))), 1'b0, '0, 0, 1'b0);
		issue(make_cmd(OP_INSERT, tbl_key[0]), 1'b0, '0, 0, 1'b0);
		issue(make_cmd(OP_INSERT, tbl_key[DEPTH-1]), 1'b0, '0, 0, 1'b0);
		issue(make_cmd(OP_LOOKUP, tbl_key[0]), 1'b0, '0, 0, 1'b0);
		issue(make_cmd(OP_LOOKUP, tbl_key[DEPTH-1]), 1'b0, '0, 0, 1'b0);
		issue(make_cmd(OP_LOOKUP, KEY_W'($urandom_range(0, 65535))), 1'b0, '0, 0, 1'b0);

		start <= 1'b0;
		// drain, then give a stray result time to show up
		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 4) @(posedge clk);
		if (mismatches == 0)
			$display("[sorted_offset_table_correct_top] OK");
		else
			$display("[sorted_offset_table_correct_top] ERROR");
		$finish;
	end

endmodule
